// ===== hw/rtl/sprd_pkg.sv =====
// Shared types, constants and helpers for the sensor response packet deframer.
package sprd_pkg;

    localparam int MAX_PAYLOAD = 128;
    localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);

    localparam logic [2:0] K_HEADER  = 3'd0;
    localparam logic [2:0] K_PAYLOAD = 3'd1;
    localparam logic [2:0] K_END     = 3'd2;
    localparam logic [2:0] K_BAD     = 3'd3;
    localparam logic [2:0] K_TIMEOUT = 3'd4;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic CFG_START_CODE    = 1'b0;
    localparam logic CFG_TIMEOUT_LIMIT = 1'b1;

    localparam logic [15:0] START_CODE_RESET    = 16'hEF01;
    localparam logic [15:0] TIMEOUT_LIMIT_RESET = 16'd1000;

    typedef struct packed {
        logic       op;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] packet_type;
        logic [7:0] payload_length;
        logic [7:0] data_byte;
        logic       last_payload;
    } t_out_item;

    typedef struct packed {
        logic [15:0] start_code;
        logic [15:0] timeout_limit;
    } t_cfg;

    function automatic logic [7:0] len_to_field(input logic [LEN_W-1:0] v);
        logic [15:0] wide;
        wide = 16'(v);
        return wide[7:0];
    endfunction

endpackage

// ===== hw/rtl/sprd_cfg.sv =====
// Configuration registers for start code and timeout limit.
module sprd_cfg
    import sprd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_code    <= START_CODE_RESET;
            r_cfg.timeout_limit <= TIMEOUT_LIMIT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_START_CODE:    r_cfg.start_code    <= i_cfg_data;
                CFG_TIMEOUT_LIMIT: r_cfg.timeout_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

// ===== hw/rtl/sprd_core.sv =====
// Deframing state machine: header parsing, payload streaming and tick timeout.
module sprd_core
    import sprd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_adv,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output logic      o_res_valid,
    output t_out_item o_res
);

    typedef enum logic [3:0] {
        S_HUNT, S_START_LO, S_ADDR0, S_ADDR1, S_ADDR2, S_ADDR3,
        S_TYPE, S_LEN_HI, S_LEN_LO, S_PAYLOAD, S_CK1, S_CK2
    } t_state;

    t_state           r_state,    n_state;
    logic             r_start_ok, n_start_ok;
    logic [7:0]       r_type,     n_type;
    logic [7:0]       r_len_hi,   n_len_hi;
    logic [LEN_W-1:0] r_remain,   n_remain;
    logic [15:0]      r_ticks,    n_ticks;

    logic [15:0]      ticks_inc;
    logic [15:0]      len16;
    logic [15:0]      len_m2;
    logic             len_bad;
    logic [LEN_W-1:0] remain_dec;
    logic [7:0]       b;

    assign b          = i_item.rx_byte;
    assign ticks_inc  = (r_ticks == 16'hFFFF) ? r_ticks : r_ticks + 16'd1;
    assign len16      = {r_len_hi, b};
    assign len_m2     = len16 - 16'd2;
    assign len_bad    = (len16 < 16'd2) || ({1'b0, len16} > 17'(MAX_PAYLOAD + 2));
    assign remain_dec = r_remain - LEN_W'(1);

    always_comb begin
        n_state     = r_state;
        n_start_ok  = r_start_ok;
        n_type      = r_type;
        n_len_hi    = r_len_hi;
        n_remain    = r_remain;
        n_ticks     = r_ticks;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (i_item.op == OP_TICK) begin
            n_ticks = ticks_inc;
            if (ticks_inc >= i_cfg.timeout_limit) begin
                n_state     = S_HUNT;
                n_start_ok  = 1'b0;
                n_len_hi    = '0;
                n_remain    = '0;
                n_ticks     = '0;
                o_res_valid = 1'b1;
                o_res.kind  = K_TIMEOUT;
            end
        end else begin
            case (r_state)
                S_HUNT: begin
                    if (b == i_cfg.start_code[15:8]) begin
                        n_state = S_START_LO;
                    end
                end
                S_START_LO: begin
                    n_start_ok = (b == i_cfg.start_code[7:0]);
                    n_state    = S_ADDR0;
                end
                S_ADDR0: n_state = S_ADDR1;
                S_ADDR1: n_state = S_ADDR2;
                S_ADDR2: n_state = S_ADDR3;
                S_ADDR3: n_state = S_TYPE;
                S_TYPE: begin
                    n_type  = b;
                    n_state = S_LEN_HI;
                end
                S_LEN_HI: begin
                    n_len_hi = b;
                    n_state  = S_LEN_LO;
                end
                S_LEN_LO: begin
                    o_res_valid = 1'b1;
                    if (!r_start_ok || len_bad) begin
                        n_state    = S_HUNT;
                        n_start_ok = 1'b0;
                        n_len_hi   = '0;
                        n_remain   = '0;
                        n_ticks    = '0;
                        o_res.kind = K_BAD;
                    end else begin
                        n_remain             = len_m2[LEN_W-1:0];
                        n_state              = (len_m2 == 16'd0) ? S_CK1 : S_PAYLOAD;
                        o_res.kind           = K_HEADER;
                        o_res.packet_type    = r_type;
                        o_res.payload_length = len_m2[7:0];
                    end
                end
                S_PAYLOAD: begin
                    n_remain = remain_dec;
                    if (remain_dec == '0) begin
                        n_state = S_CK1;
                    end
                    o_res_valid          = 1'b1;
                    o_res.kind           = K_PAYLOAD;
                    o_res.packet_type    = r_type;
                    o_res.payload_length = len_to_field(remain_dec);
                    o_res.data_byte      = b;
                    o_res.last_payload   = (remain_dec == '0);
                end
                S_CK1: n_state = S_CK2;
                S_CK2: begin
                    n_state           = S_HUNT;
                    n_start_ok        = 1'b0;
                    n_len_hi          = '0;
                    n_remain          = '0;
                    n_ticks           = '0;
                    o_res_valid       = 1'b1;
                    o_res.kind        = K_END;
                    o_res.packet_type = r_type;
                end
                default: begin
                    n_state    = S_HUNT;
                    n_start_ok = 1'b0;
                    n_len_hi   = '0;
                    n_remain   = '0;
                    n_ticks    = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_HUNT;
            r_start_ok <= 1'b0;
            r_type     <= '0;
            r_len_hi   <= '0;
            r_remain   <= '0;
            r_ticks    <= '0;
        end else if (i_adv) begin
            r_state    <= n_state;
            r_start_ok <= n_start_ok;
            r_type     <= n_type;
            r_len_hi   <= n_len_hi;
            r_remain   <= n_remain;
            r_ticks    <= n_ticks;
        end
    end

    a_payload_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_PAYLOAD |-> r_remain != '0)
        else $error("Payload state entered with no bytes remaining.");

    a_remain_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_remain} <= (LEN_W + 1)'(MAX_PAYLOAD))
        else $error("Remaining payload count exceeds the bound.");

    a_finish_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && o_res_valid &&
        (o_res.kind == K_END || o_res.kind == K_BAD || o_res.kind == K_TIMEOUT)
        |=> r_state == S_HUNT && r_ticks == 16'd0)
        else $error("Packet end, bad packet or timeout did not return to hunting.");

    a_last_marks_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.last_payload
        |-> o_res.kind == K_PAYLOAD && o_res.payload_length == 8'd0)
        else $error("Last payload flag on a result that is not the final byte.");

endmodule

// ===== hw/rtl/sensor_response_packet_deframer.sv =====
// Top level of the sensor response packet deframer.
//
//   Channel  Direction  Handshake                 Payload
//   input    in         i_in_valid / o_in_stall   i_in_data  (op, rx_byte)
//   output   out        o_out_valid / i_out_stall o_out_data (kind, type, length, data, last)
//   config   in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One item enters every cycle unless the output stalls. An item is held in the input
// register and its result in the result register; both advance whenever the result
// register is empty or being drained, so the block stalls only behind a stalled output.
// Reset is synchronous and returns the deframer to hunting with the tick count cleared.
// Configuration writes are taken in any cycle with no wait.
module sensor_response_packet_deframer
    import sprd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_cfg      cfg;
    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    logic      out_adv;
    logic      res_valid;
    t_out_item res;

    assign out_adv     = !r_out_valid || !i_out_stall;
    assign o_in_stall  = r_in_valid && !out_adv;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

    sprd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    sprd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (r_in_valid && out_adv),
        .i_item      (r_in_item),
        .i_cfg       (cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (out_adv) begin
                r_out_valid <= r_in_valid && res_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in_item <= i_in_data;
        end
        if (out_adv) begin
            r_out_item <= res;
        end
    end

endmodule

// ===== tb/sensor_response_packet_deframer_tb.sv =====
// Self-checking testbench for the sensor response packet deframer.
`timescale 1ns / 1ps

module sensor_response_packet_deframer_tb;
    import sprd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;

    localparam logic [3:0] POS_HUNT     = 4'd0;
    localparam logic [3:0] POS_START_LO = 4'd1;
    localparam logic [3:0] POS_TYPE     = 4'd6;
    localparam logic [3:0] POS_LEN_HI   = 4'd7;
    localparam logic [3:0] POS_LEN_LO   = 4'd8;
    localparam logic [3:0] POS_PAYLOAD  = 4'd9;
    localparam logic [3:0] POS_CK1      = 4'd10;
    localparam logic [3:0] POS_CK2      = 4'd11;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in_item    i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_item   o_out_data;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = CFG_START_CODE;
    logic [15:0] i_cfg_data = '0;

    t_in_item  rx_stream[$];
    t_out_item expected_results[$];

    int error_count = 0;
    int cycle_count = 0;
    int idle_pct = 8;
    int tick_pct = 0;
    int queued_total = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;
    bit in_xfer = 1'b0;

    logic [15:0] cur_start = START_CODE_RESET;
    logic [15:0] cur_limit = TIMEOUT_LIMIT_RESET;
    logic [3:0]  frame_pos = POS_HUNT;
    logic        start_match = 1'b0;
    logic [7:0]  held_type = '0;
    logic [15:0] held_len = '0;
    logic [15:0] tick_count = '0;

    sensor_response_packet_deframer DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic void clear_frame();
        frame_pos   = POS_HUNT;
        start_match = 1'b0;
        held_len    = '0;
        tick_count  = '0;
    endfunction

    function automatic bit deframe_predict(input t_in_item it, output t_out_item res);
        logic [15:0] full_len;
        bit          hit;
        hit = 1'b0;
        res = '0;
        if (it.op == OP_TICK) begin
            if (tick_count != 16'hFFFF) tick_count = tick_count + 16'd1;
            if (tick_count >= cur_limit) begin
                clear_frame();
                res.kind = K_TIMEOUT;
                hit = 1'b1;
            end
            return hit;
        end
        case (frame_pos)
            POS_HUNT: begin
                if (it.rx_byte == cur_start[15:8]) frame_pos = POS_START_LO;
            end
            POS_START_LO: begin
                start_match = (it.rx_byte == cur_start[7:0]);
                frame_pos = frame_pos + 4'd1;
            end
            POS_TYPE: begin
                held_type = it.rx_byte;
                frame_pos = POS_LEN_HI;
            end
            POS_LEN_HI: begin
                held_len = {it.rx_byte, 8'h00};
                frame_pos = POS_LEN_LO;
            end
            POS_LEN_LO: begin
                full_len = {held_len[15:8], it.rx_byte};
                hit = 1'b1;
                if (!start_match || full_len < 16'd2 || full_len - 16'd2 > MAX_PAYLOAD) begin
                    clear_frame();
                    res.kind = K_BAD;
                end else begin
                    held_len = full_len - 16'd2;
                    frame_pos = (held_len == 16'd0) ? POS_CK1 : POS_PAYLOAD;
                    res.kind = K_HEADER;
                    res.packet_type = held_type;
                    res.payload_length = held_len[7:0];
                end
            end
            POS_PAYLOAD: begin
                if (held_len != 16'd0) held_len = held_len - 16'd1;
                if (held_len == 16'd0) frame_pos = POS_CK1;
                hit = 1'b1;
                res.kind = K_PAYLOAD;
                res.packet_type = held_type;
                res.payload_length = held_len[7:0];
                res.data_byte = it.rx_byte;
                res.last_payload = (held_len == 16'd0);
            end
            POS_CK1: begin
                frame_pos = POS_CK2;
            end
            POS_CK2: begin
                clear_frame();
                hit = 1'b1;
                res.kind = K_END;
                res.packet_type = held_type;
            end
            default: begin
                frame_pos = frame_pos + 4'd1;
            end
        endcase
        return hit;
    endfunction

    task automatic add_tick();
        t_in_item it;
        it.op = OP_TICK;
        it.rx_byte = 8'($urandom);
        rx_stream.push_back(it);
        queued_total++;
    endtask

    task automatic add_byte(input logic [7:0] b);
        t_in_item it;
        if ($urandom_range(0, 99) < tick_pct) add_tick();
        it.op = OP_BYTE;
        it.rx_byte = b;
        rx_stream.push_back(it);
        queued_total++;
    endtask

    task automatic add_packet(input logic [7:0] ptype, input logic [15:0] len_field,
                              input bit start_ok, input int trailer);
        int k;
        add_byte(cur_start[15:8]);
        add_byte(start_ok ? cur_start[7:0] : cur_start[7:0] ^ 8'($urandom_range(1, 255)));
        for (k = 0; k < 4; k++) add_byte(8'($urandom));
        add_byte(ptype);
        add_byte(len_field[15:8]);
        add_byte(len_field[7:0]);
        for (k = 0; k < trailer; k++) add_byte(8'($urandom));
    endtask

    task automatic add_traffic(input int n_items);
        int          target;
        int          sel;
        int          size_sel;
        int          plen;
        int          k;
        logic [15:0] bad_len;
        target = queued_total + n_items;
        while (queued_total < target) begin
            sel = $urandom_range(0, 99);
            size_sel = $urandom_range(0, 99);
            if (size_sel < 4) plen = MAX_PAYLOAD;
            else if (size_sel < 14) plen = $urandom_range(0, MAX_PAYLOAD);
            else plen = $urandom_range(0, 6);
            if (sel < 70) begin
                add_packet(8'($urandom), 16'(plen + 2), 1'b1, plen + 2);
            end else if (sel < 82) begin
                case ($urandom_range(0, 3))
                    0: bad_len = 16'($urandom_range(0, 1));
                    1: bad_len = 16'(MAX_PAYLOAD + 3);
                    2: bad_len = 16'($urandom_range(MAX_PAYLOAD + 3, 16'hFFFF));
                    default: bad_len = 16'($urandom_range(2, 10));
                endcase
                add_packet(8'($urandom), bad_len, (bad_len > 16'd10) ? sel[0] : 1'b0,
                           $urandom_range(0, 3));
            end else if (sel < 90) begin
                add_packet(8'($urandom), 16'(plen + 2), 1'b1, $urandom_range(0, plen + 1));
            end else begin
                for (k = $urandom_range(1, 6); k > 0; k--) begin
                    if ($urandom_range(0, 99) < 30) add_tick();
                    else add_byte(8'($urandom));
                end
            end
        end
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (rx_stream.size() != 0 || i_in_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    always @(negedge i_clk) begin : driver
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_xfer) begin
            if (rx_stream.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                i_in_data  <= rx_stream.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin : receiver
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < idle_pct);
        end
    end

    always @(posedge i_clk) begin : monitor
        t_out_item want;
        t_out_item got;
        in_xfer = 1'b0;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                in_xfer = 1'b1;
                if (deframe_predict(i_in_data, want)) expected_results.push_back(want);
            end
            if (o_out_valid && !i_out_stall) begin
                got = o_out_data;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %h", $time, got);
                    error_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.kind !== want.kind || got.packet_type !== want.packet_type ||
                        got.payload_length !== want.payload_length ||
                        got.data_byte !== want.data_byte ||
                        got.last_payload !== want.last_payload) begin
                        $display({"%0t: result mismatch, expected kind %0d type %h ",
                                  "length %0d data %h last %b, got kind %0d type %h ",
                                  "length %0d data %h last %b"}, $time,
                                 want.kind, want.packet_type, want.payload_length,
                                 want.data_byte, want.last_payload,
                                 got.kind, got.packet_type, got.payload_length,
                                 got.data_byte, got.last_payload);
                        error_count++;
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_START_CODE:    cur_start = i_cfg_data;
                    CFG_TIMEOUT_LIMIT: cur_limit = i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("sensor_response_packet_deframer test failed");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty payload with an all-ones type, then a wrong second start byte.
        add_packet(8'hFF, 16'd2, 1'b1, 2);
        add_packet(8'h00, 16'd3, 1'b0, 0);
        wait_drained();

        // A limit of one: every tick ends the reception. Length field below two.
        write_reg(CFG_START_CODE, 16'h0000);
        write_reg(CFG_TIMEOUT_LIMIT, 16'd1);
        add_tick();
        add_packet(8'hA5, 16'd1, 1'b1, 0);
        add_tick();
        wait_drained();

        // A stretch with no idling on either side.
        write_reg(CFG_START_CODE, 16'hFFFF);
        write_reg(CFG_TIMEOUT_LIMIT, 16'hFFFF);
        idle_pct = 0;
        tick_pct = 2;
        add_traffic(150);
        wait_drained();

        write_reg(CFG_START_CODE, 16'($urandom));
        write_reg(CFG_TIMEOUT_LIMIT, 16'($urandom_range(8, 40)));
        idle_pct = 8;
        tick_pct = 4;
        add_traffic(250);
        wait_drained();

        // The receiver holds off for a long stretch while transfers keep being offered.
        write_reg(CFG_START_CODE, START_CODE_RESET);
        write_reg(CFG_TIMEOUT_LIMIT, TIMEOUT_LIMIT_RESET);
        tick_pct = 1;
        add_traffic(250);
        hold_req++;
        wait_drained();
        repeat (10) @(posedge i_clk);

        if (error_count == 0) begin
            $display("sensor_response_packet_deframer test passed");
        end else begin
            $display("sensor_response_packet_deframer test failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/sprd_pkg.sv
hw/rtl/sprd_cfg.sv
hw/rtl/sprd_core.sv
hw/rtl/sensor_response_packet_deframer.sv
tb/sensor_response_packet_deframer_tb.sv
